@@ design/bit_vector_rank_directory_core_assert.svh @@
// Assertion macros used by the rank directory back end.
// Every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef BIT_VECTOR_RANK_DIRECTORY_CORE_ASSERT_SVH
`define BIT_VECTOR_RANK_DIRECTORY_CORE_ASSERT_SVH

// Property that must hold at every clock edge.
`define BVRD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define BVRD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

@@ design/bvrd_pkg.sv @@
// ----------------------------------------------------------------------------
// bvrd_pkg
// Types and constants shared by the front end, command queue and back end
// of the bit vector rank directory.
// ----------------------------------------------------------------------------
package bvrd_pkg;

  localparam int unsigned MAX_BITS   = 65536;
  localparam int unsigned POS_W      = 17;

  // Bit store is kept as 8-bit words.
  localparam int unsigned WORD_DEPTH = MAX_BITS / 8;
  localparam int unsigned WORD_AW    = 13;
  localparam int unsigned BKT_DEPTH  = MAX_BITS / 8 + 1;
  localparam int unsigned BKT_AW     = 14;
  localparam int unsigned BKT_W      = 12;
  localparam int unsigned SB_DEPTH   = MAX_BITS / 64 + 1;
  localparam int unsigned SB_AW      = 11;

  localparam logic [6:0] BSIZE_MIN   = 7'd8;
  localparam logic [6:0] BSIZE_MAX   = 7'd64;
  localparam logic [6:0] BSIZE_RESET = 7'd16;

  localparam logic [1:0] MODE_APPEND = 2'd0;
  localparam logic [1:0] MODE_QUERY  = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;
  localparam logic [1:0] MODE_NOP    = 2'd3;

  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_QUERY  = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_PASS   = 2'd3
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e            op;
    logic               bit_v;
    logic [POS_W-1:0]   pos;
    logic [POS_W-1:0]   rank;
    logic               err;
  } cmd_t;

endpackage

@@ design/bvrd_ram.sv @@
// ----------------------------------------------------------------------------
// bvrd_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data that holds while the read enable is low.
// ----------------------------------------------------------------------------
module bvrd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

@@ design/bvrd_fifo.sv @@
// ----------------------------------------------------------------------------
// bvrd_fifo
// Four-entry command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module bvrd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  bvrd_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output bvrd_pkg::cmd_t cmd_o
);
  import bvrd_pkg::*;

  cmd_t       mem_q [4];
  logic [1:0] wptr_q, rptr_q;
  logic [2:0] cnt_q;

  assign full_o  = (cnt_q == 3'd4);
  assign empty_o = (cnt_q == 3'd0);
  assign cmd_o   = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 2'd0;
      rptr_q <= 2'd0;
      cnt_q  <= 3'd0;
    end else begin
      if (push_i) wptr_q <= wptr_q + 2'd1;
      if (pop_i)  rptr_q <= rptr_q + 2'd1;
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 3'd1;
        2'b01:   cnt_q <= cnt_q - 3'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

@@ design/bvrd_div.sv @@
// ----------------------------------------------------------------------------
// bvrd_div
// Restoring divider, 17-bit dividend by 7-bit divisor, two quotient bits
// per cycle; done pulses in the cycle after the ninth step.
// ----------------------------------------------------------------------------
module bvrd_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [16:0] dividend_i,
  input  logic [6:0]  divisor_i,
  output logic        done_o,
  output logic [16:0] quotient_o,
  output logic [6:0]  remainder_o
);

  localparam logic [3:0] LastStep = 4'd8;

  logic        busy_q, done_q;
  logic [3:0]  cnt_q;
  logic [6:0]  div_q, rem_q, rem_d;
  logic [17:0] quo_q, quo_d;

  always_comb begin
    logic [7:0]  t;
    logic [6:0]  r;
    logic [17:0] q;
    r = rem_q;
    q = quo_q;
    t = 8'd0;
    for (int s = 0; s < 2; s++) begin
      t = {r, q[17]};
      q = {q[16:0], 1'b0};
      if (t >= {1'b0, div_q}) begin
        t    = t - {1'b0, div_q};
        q[0] = 1'b1;
      end
      r = t[6:0];
    end
    rem_d = r;
    quo_d = q;
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      div_q <= divisor_i;
      rem_q <= 7'd0;
      quo_q <= {1'b0, dividend_i};
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 4'd0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 4'd0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 4'd1;
        if (cnt_q == LastStep) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q[16:0];
  assign remainder_o = rem_q;

endmodule

@@ design/bvrd_front.sv @@
// ----------------------------------------------------------------------------
// bvrd_front
// Accepts input items, tracks loaded length and ones count, and turns each
// item into a command with its error check and, where known, its result.
// ----------------------------------------------------------------------------
module bvrd_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic           accept_i,
  input  logic [1:0]     mode_i,
  input  logic           bit_value_i,
  input  logic [16:0]    query_position_i,
  output bvrd_pkg::cmd_t cmd_o
);
  import bvrd_pkg::*;

  logic [POS_W-1:0] len_q, len_d, ones_q, ones_d;
  cmd_t             cmd;

  always_comb begin
    cmd       = '0;
    cmd.op    = CMD_PASS;
    cmd.bit_v = bit_value_i;
    cmd.pos   = query_position_i;
    cmd.rank  = ones_q;
    len_d     = len_q;
    ones_d    = ones_q;
    unique case (mode_i)
      MODE_APPEND: begin
        if (len_q == POS_W'(MAX_BITS)) begin
          cmd.err = 1'b1;
        end else begin
          cmd.op   = CMD_APPEND;
          cmd.pos  = len_q;
          cmd.rank = ones_q + {16'd0, bit_value_i};
          len_d    = len_q + 17'd1;
          ones_d   = cmd.rank;
        end
      end
      MODE_QUERY: begin
        if (query_position_i > len_q) begin
          cmd.rank = '0;
          cmd.err  = 1'b1;
        end else begin
          cmd.op = CMD_QUERY;
        end
      end
      MODE_CLEAR: begin
        cmd.op   = CMD_CLEAR;
        cmd.rank = '0;
        len_d    = '0;
        ones_d   = '0;
      end
      MODE_NOP: begin
        cmd.op = CMD_PASS;
      end
      default: cmd.op = CMD_PASS;
    endcase
  end

  assign cmd_o = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= '0;
      ones_q <= '0;
    end else if (cfg_we_i) begin
      len_q  <= '0;
      ones_q <= '0;
    end else if (accept_i) begin
      len_q  <= len_d;
      ones_q <= ones_d;
    end
  end

endmodule

@@ design/bvrd_back.sv @@
// ----------------------------------------------------------------------------
// bvrd_back
// Carries out commands: writes the bit store on append, the directories when
// buckets close, runs rank queries via divider and word scan, holds the result.
// ----------------------------------------------------------------------------
module bvrd_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [6:0]     cfg_wdata_i,
  input  logic           cmd_empty_i,
  input  bvrd_pkg::cmd_t cmd_i,
  output logic           cmd_pop_o,
  input  logic           pop,
  output logic           empty,
  output logic [16:0]    rank_value_o,
  output logic           error_o
);
  import bvrd_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_DIV1 = 7'b0000010,
    S_DIV2 = 7'b0000100,
    S_DIR  = 7'b0001000,
    S_SCAN = 7'b0010000,
    S_LAST = 7'b0100000,
    S_EMIT = 7'b1000000
  } state_e;

  function automatic logic [3:0] popcnt8(logic [7:0] v);
    logic [3:0] c;
    c = 4'd0;
    for (int j = 0; j < 8; j++) begin
      c = c + {3'd0, v[j]};
    end
    return c;
  endfunction

  function automatic logic [7:0] word_mask(logic [WORD_AW-1:0] w, logic [WORD_AW-1:0] sw,
                                           logic [2:0] lo, logic [WORD_AW-1:0] ew,
                                           logic [2:0] hi);
    logic [7:0] m;
    m = 8'd0;
    for (int j = 0; j < 8; j++) begin
      m[j] = ((w != sw) || (3'(j) >= lo)) && ((w != ew) || (3'(j) <= hi));
    end
    return m;
  endfunction

  state_e              state_q, state_d;
  logic [6:0]          bsize_q, bsize_d;
  logic [5:0]          off_q, off_d, insb_q, insb_d;
  logic [BKT_AW-1:0]   bi_q, bi_d;
  logic [SB_AW-1:0]    si_q, si_d;
  logic [POS_W-1:0]    base_q, base_d;
  logic [7:0]          word_q, word_d;

  logic [POS_W-1:0]    pos_q, pos_d;
  logic [BKT_AW-1:0]   qbi_q, qbi_d;
  logic [SB_AW-1:0]    qsi_q, qsi_d;
  logic [5:0]          r_q, r_d;
  logic [WORD_AW-1:0]  w_q, w_d, sw_q, sw_d, ew_q, ew_d;
  logic [2:0]          lo_q, lo_d, hi_q, hi_d;
  logic [7:0]          mask_q, mask_d;
  logic                pend_q, pend_d;
  logic [5:0]          sum_q, sum_d;

  logic                out_v_q;
  logic [POS_W-1:0]    out_rank_q;
  logic                out_err_q;
  logic                emit, emit_err;
  logic [POS_W-1:0]    emit_rank;
  logic                slot_free;

  logic                div_start, div_done;
  logic [16:0]         div_dividend, div_quo;
  logic [6:0]          div_rem;

  logic                word_we, word_re;
  logic [WORD_AW-1:0]  word_waddr, word_raddr;
  logic [7:0]          word_rdata;
  logic                bkt_we, bkt_re;
  logic [BKT_AW-1:0]   bkt_waddr;
  logic [BKT_W-1:0]    bkt_wdata, bkt_rdata;
  logic                sb_we, sb_re;
  logic [SB_AW-1:0]    sb_waddr;
  logic [POS_W-1:0]    sb_wdata, sb_rdata;

  logic [POS_W-1:0]    start_v, last_v, bkt_part, sb_part;

  assign slot_free = !out_v_q || pop;
  assign start_v   = pos_q - {11'd0, r_q};
  assign last_v    = pos_q - 17'd1;
  assign bkt_part  = (qbi_q == '0) ? '0 : {5'd0, bkt_rdata};
  assign sb_part   = (qsi_q == '0) ? '0 : sb_rdata;

  always_comb begin
    state_d      = state_q;
    bsize_d      = bsize_q;
    off_d        = off_q;
    insb_d       = insb_q;
    bi_d         = bi_q;
    si_d         = si_q;
    base_d       = base_q;
    word_d       = word_q;
    pos_d        = pos_q;
    qbi_d        = qbi_q;
    qsi_d        = qsi_q;
    r_d          = r_q;
    w_d          = w_q;
    sw_d         = sw_q;
    ew_d         = ew_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    mask_d       = mask_q;
    pend_d       = pend_q;
    sum_d        = sum_q;
    cmd_pop_o    = 1'b0;
    emit         = 1'b0;
    emit_rank    = cmd_i.rank;
    emit_err     = cmd_i.err;
    div_start    = 1'b0;
    div_dividend = cmd_i.pos;
    word_we      = 1'b0;
    word_re      = 1'b0;
    word_waddr   = cmd_i.pos[WORD_AW+2:3];
    word_raddr   = w_q;
    bkt_we       = 1'b0;
    bkt_re       = 1'b0;
    bkt_waddr    = bi_q + BKT_AW'(1);
    bkt_wdata    = '0;
    sb_we        = 1'b0;
    sb_re        = 1'b0;
    sb_waddr     = si_q + SB_AW'(1);
    sb_wdata     = cmd_i.rank;

    unique case (state_q)
      S_IDLE: begin
        if (!cmd_empty_i) begin
          unique case (cmd_i.op)
            CMD_QUERY: begin
              cmd_pop_o = 1'b1;
              pos_d     = cmd_i.pos;
              div_start = 1'b1;
              state_d   = S_DIV1;
            end
            CMD_APPEND: begin
              if (slot_free) begin
                cmd_pop_o = 1'b1;
                emit      = 1'b1;
                word_d    = (cmd_i.pos[2:0] == 3'd0) ? 8'd0 : word_q;
                word_d[cmd_i.pos[2:0]] = cmd_i.bit_v;
                word_we   = 1'b1;
                // Close the bucket, and the superblock too when it fills.
                if ({1'b0, off_q} == bsize_q - 7'd1) begin
                  off_d  = '0;
                  bi_d   = bi_q + BKT_AW'(1);
                  bkt_we = 1'b1;
                  if ({1'b0, insb_q} == bsize_q - 7'd1) begin
                    insb_d    = '0;
                    si_d      = si_q + SB_AW'(1);
                    sb_we     = 1'b1;
                    base_d    = cmd_i.rank;
                    bkt_wdata = '0;
                  end else begin
                    insb_d    = insb_q + 6'd1;
                    bkt_wdata = BKT_W'(cmd_i.rank - base_q);
                  end
                end else begin
                  off_d = off_q + 6'd1;
                end
              end
            end
            CMD_CLEAR: begin
              if (slot_free) begin
                cmd_pop_o = 1'b1;
                emit      = 1'b1;
                off_d     = '0;
                insb_d    = '0;
                bi_d      = '0;
                si_d      = '0;
                base_d    = '0;
              end
            end
            CMD_PASS: begin
              if (slot_free) begin
                cmd_pop_o = 1'b1;
                emit      = 1'b1;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_DIV1: begin
        div_dividend = {3'd0, div_quo[BKT_AW-1:0]};
        if (div_done) begin
          qbi_d     = div_quo[BKT_AW-1:0];
          r_d       = div_rem[5:0];
          div_start = 1'b1;
          state_d   = S_DIV2;
        end
      end
      S_DIV2: begin
        if (div_done) begin
          qsi_d   = div_quo[SB_AW-1:0];
          state_d = S_DIR;
        end
      end
      S_DIR: begin
        bkt_re  = 1'b1;
        sb_re   = 1'b1;
        sw_d    = start_v[WORD_AW+2:3];
        lo_d    = start_v[2:0];
        ew_d    = last_v[WORD_AW+2:3];
        hi_d    = last_v[2:0];
        w_d     = start_v[WORD_AW+2:3];
        sum_d   = '0;
        pend_d  = 1'b0;
        state_d = (r_q == '0) ? S_LAST : S_SCAN;
      end
      S_SCAN: begin
        word_re = 1'b1;
        mask_d  = word_mask(w_q, sw_q, lo_q, ew_q, hi_q);
        pend_d  = 1'b1;
        if (pend_q) begin
          sum_d = sum_q + {2'd0, popcnt8(word_rdata & mask_q)};
        end
        w_d = w_q + WORD_AW'(1);
        if (w_q == ew_q) begin
          state_d = S_LAST;
        end
      end
      S_LAST: begin
        if (pend_q) begin
          sum_d = sum_q + {2'd0, popcnt8(word_rdata & mask_q)};
        end
        pend_d  = 1'b0;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_rank = {11'd0, sum_q} + bkt_part + sb_part;
          emit_err  = 1'b0;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // A new bucket size starts a new vector.
    if (cfg_we_i) begin
      if (cfg_wdata_i < BSIZE_MIN) begin
        bsize_d = BSIZE_MIN;
      end else if (cfg_wdata_i > BSIZE_MAX) begin
        bsize_d = BSIZE_MAX;
      end else begin
        bsize_d = cfg_wdata_i;
      end
      off_d  = '0;
      insb_d = '0;
      bi_d   = '0;
      si_d   = '0;
      base_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      bsize_q <= BSIZE_RESET;
      off_q   <= '0;
      insb_q  <= '0;
      bi_q    <= '0;
      si_q    <= '0;
      base_q  <= '0;
      pend_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      bsize_q <= bsize_d;
      off_q   <= off_d;
      insb_q  <= insb_d;
      bi_q    <= bi_d;
      si_q    <= si_d;
      base_q  <= base_d;
      pend_q  <= pend_d;
      if (emit) begin
        out_v_q <= 1'b1;
      end else if (pop) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    pos_q  <= pos_d;
    qbi_q  <= qbi_d;
    qsi_q  <= qsi_d;
    r_q    <= r_d;
    w_q    <= w_d;
    sw_q   <= sw_d;
    ew_q   <= ew_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    mask_q <= mask_d;
    sum_q  <= sum_d;
    if (emit) begin
      out_rank_q <= emit_rank;
      out_err_q  <= emit_err;
    end
  end

  assign empty        = !out_v_q;
  assign rank_value_o = out_rank_q;
  assign error_o      = out_err_q;

  bvrd_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (bsize_q),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  bvrd_ram #(.WIDTH(8), .DEPTH(8192)) u_word_ram (
    .clk_i   (clk_i),
    .we_i    (word_we),
    .waddr_i (word_waddr),
    .wdata_i (word_d),
    .re_i    (word_re),
    .raddr_i (word_raddr),
    .rdata_o (word_rdata)
  );

  bvrd_ram #(.WIDTH(12), .DEPTH(8193)) u_bkt_ram (
    .clk_i   (clk_i),
    .we_i    (bkt_we),
    .waddr_i (bkt_waddr),
    .wdata_i (bkt_wdata),
    .re_i    (bkt_re),
    .raddr_i (qbi_q),
    .rdata_o (bkt_rdata)
  );

  bvrd_ram #(.WIDTH(17), .DEPTH(1025)) u_sb_ram (
    .clk_i   (clk_i),
    .we_i    (sb_we),
    .waddr_i (sb_waddr),
    .wdata_i (sb_wdata),
    .re_i    (sb_re),
    .raddr_i (qsi_q),
    .rdata_o (sb_rdata)
  );

`include "bit_vector_rank_directory_core_assert.svh"

  `BVRD_ASSERT(a_bsize_range, (bsize_q >= BSIZE_MIN) && (bsize_q <= BSIZE_MAX), "bucket size out of range")
  `BVRD_ASSERT(a_off_in_bucket, {1'b0, off_q} < bsize_q, "bucket offset past bucket size")
  `BVRD_ASSERT_IMPL(a_pop_idle, cmd_pop_o, state_q == S_IDLE, "command taken while busy")
  `BVRD_ASSERT_IMPL(a_div_done_state, div_done, (state_q == S_DIV1) || (state_q == S_DIV2), "divider finished outside a query")
  `BVRD_ASSERT_IMPL(a_emit_slot, emit, slot_free, "result written over a waiting result")

endmodule

@@ design/bit_vector_rank_directory_core.sv @@
// ----------------------------------------------------------------------------
// bit_vector_rank_directory_core
// Bit vector with a two-level rank directory: append bits, query rank,
// clear the vector.
//
//   channel   signals                                    handshake
//   input     mode_i, bit_value_i, query_position_i      push / full
//   result    rank_value_o, error_o                      empty / pop
//   config    cfg_wdata_i (bucket size)                  cfg_we_i
//
// Append, clear and rejected items are each carried out in the idle state.
// A query runs in steps: the command pop, two runs of the 2-bit-per-cycle
// divider, one directory read, one bit-store word per cycle over the up to 9
// words of the partial bucket, a last-word step and the emit step, which
// waits until the output register is free.
// Reset is asynchronous; directory entries are never cleared, index zero
// reads as zero and every other entry read was written in the same vector.
// A 4-entry command queue and one output register decouple the two sides.
// ----------------------------------------------------------------------------
module bit_vector_rank_directory_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [6:0]  cfg_wdata_i,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  mode_i,
  input  logic        bit_value_i,
  input  logic [16:0] query_position_i,
  output logic        empty,
  input  logic        pop,
  output logic [16:0] rank_value_o,
  output logic        error_o
);
  import bvrd_pkg::*;

  cmd_t front_cmd, head_cmd;
  logic accept, q_empty, q_pop;

  assign accept = push && !full;

  bvrd_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .accept_i         (accept),
    .mode_i           (mode_i),
    .bit_value_i      (bit_value_i),
    .query_position_i (query_position_i),
    .cmd_o            (front_cmd)
  );

  bvrd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .cmd_i   (front_cmd),
    .full_o  (full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .cmd_o   (head_cmd)
  );

  bvrd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .cmd_empty_i  (q_empty),
    .cmd_i        (head_cmd),
    .cmd_pop_o    (q_pop),
    .pop          (pop),
    .empty        (empty),
    .rank_value_o (rank_value_o),
    .error_o      (error_o)
  );

endmodule
